[hw/rtl/dwmd_pkg.sv]
package dwmd_pkg;

  localparam int MAX_WINDOW    = 16;
  localparam int ALPHABET_SIZE = 256;

  localparam int SYM_W = 8;
  localparam int WS_W  = 5;
  localparam int POS_W = 20;

  // fill counter holds 0..MAX_WINDOW
  localparam int CNT_W = $clog2(MAX_WINDOW + 1);
  // common width for comparing the window size register against the fill
  localparam int CMP_W = (CNT_W > WS_W) ? CNT_W : WS_W;

  localparam logic [CNT_W-1:0] FILL_MAX = CNT_W'(MAX_WINDOW);
  localparam logic [POS_W-1:0] POS_MAX  = {POS_W{1'b1}};
  localparam logic [WS_W-1:0]  WS_RESET = WS_W'(4);
  localparam logic [SYM_W-1:0] SYM_TOP  = SYM_W'(ALPHABET_SIZE - 1);

  localparam int OUT_DATA_W = ((POS_W + 7) / 8) * 8;

  typedef struct packed {
    logic             found;
    logic [POS_W-1:0] position;
  } out_word_t;

  typedef logic [SYM_W-1:0] sym_t;

endpackage

[hw/rtl/distinct_window_marker_detect.sv]
// Distinct-window marker detector.
// Input channel (in_*): one byte of a line per word. in_tuser marks the first
// byte of a line (state is cleared before it), in_tlast marks the last one.
// Output channel (out_*): one word per marker or per line that ended without
// one. out_tdata carries the 1-based position of the marker end (or the line
// length), out_tuser is 1 for a marker, 0 for a line with none.
// Configuration: cfg_wen/cfg_wdata write the window size (0 acts as 1, values
// above the window depth act as the depth); a write also clears line state.
// Throughput: one byte per cycle while in_tready is high. The all-distinct test compares every pair
// of bytes in a byte-wide shift line in the same cycle the byte is taken.
// Each result is registered in the output register, or in the skid register.
// Stall: an output register plus one skid register; in_tready drops only when
// both hold results, so two results can pile up before input stops.
// Reset: synchronous, active low; window size returns to 4, line state clears,
// both output slots empty.
module distinct_window_marker_detect (
  input  logic                               clk,
  input  logic                               rst_n,
  // slave side
  input  logic                               in_tvalid,
  output logic                               in_tready,
  input  logic [7:0]                         in_tdata,   // [7:0] symbol
  input  logic                               in_tuser,   // [0] line_start
  input  logic                               in_tlast,   // line_end
  // master side
  output logic                               out_tvalid,
  input  logic                               out_tready,
  output logic [dwmd_pkg::OUT_DATA_W-1:0]    out_tdata,  // [19:0] position, rest 0
  output logic                               out_tuser,  // [0] found
  // configuration
  input  logic                               cfg_wen,
  input  logic [dwmd_pkg::WS_W-1:0]          cfg_wdata   // window_size
);

  // ---------------------------------------------------------------- state
  logic [dwmd_pkg::WS_W-1:0]  ws_r;
  dwmd_pkg::sym_t             win_r [dwmd_pkg::MAX_WINDOW];
  dwmd_pkg::sym_t             win_nxt [dwmd_pkg::MAX_WINDOW];
  logic [dwmd_pkg::CNT_W-1:0] fill_r, fill_nxt;
  logic [dwmd_pkg::POS_W-1:0] idx_r, idx_nxt;
  logic                       done_r, done_nxt;

  dwmd_pkg::out_word_t        out_r, skid_r, res;
  logic                       out_valid_r, skid_valid_r;

  logic                       accept, pop, emit, hit, dup;
  logic [dwmd_pkg::CNT_W-1:0] w_eff;
  logic [dwmd_pkg::CNT_W-1:0] fill_eff, fill_inc;
  logic [dwmd_pkg::POS_W-1:0] idx_eff;
  logic                       done_eff;
  dwmd_pkg::sym_t             sym;

  assign in_tready  = !skid_valid_r;
  assign accept     = in_tvalid && in_tready;
  assign pop        = out_valid_r && out_tready;

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_r.found;
  assign out_tdata  = dwmd_pkg::OUT_DATA_W'(out_r.position);

  // effective window: clamp 0 up to 1 and anything past the depth down to it
  always_comb begin
    if (ws_r == '0) begin
      w_eff = dwmd_pkg::CNT_W'(1);
    end else if (dwmd_pkg::CMP_W'(ws_r) > dwmd_pkg::CMP_W'(dwmd_pkg::MAX_WINDOW)) begin
      w_eff = dwmd_pkg::FILL_MAX;
    end else begin
      w_eff = dwmd_pkg::CNT_W'(ws_r);
    end
  end

  assign sym = (in_tdata > dwmd_pkg::SYM_TOP) ? dwmd_pkg::SYM_TOP : in_tdata;

  // line_start acts as a clear ahead of this byte
  assign fill_eff = in_tuser ? '0 : fill_r;
  assign idx_eff  = in_tuser ? '0 : idx_r;
  assign done_eff = in_tuser ? 1'b0 : done_r;

  assign fill_inc = (fill_eff == dwmd_pkg::FILL_MAX) ? fill_eff : fill_eff + 1'b1;
  assign idx_nxt  = (idx_eff == dwmd_pkg::POS_MAX) ? idx_eff : idx_eff + 1'b1;

  // shifted window; entries at or past the fill count never decide a hit
  always_comb begin
    win_nxt[0] = sym;
    for (int k = 1; k < dwmd_pkg::MAX_WINDOW; k++) begin
      win_nxt[k] = win_r[k-1];
    end
  end

  // any equal pair among the newest w_eff bytes
  always_comb begin
    dup = 1'b0;
    for (int i = 0; i < dwmd_pkg::MAX_WINDOW - 1; i++) begin
      for (int j = i + 1; j < dwmd_pkg::MAX_WINDOW; j++) begin
        if ((dwmd_pkg::CNT_W'(j) < w_eff) && (win_nxt[i] == win_nxt[j])) begin
          dup = 1'b1;
        end
      end
    end
  end

  assign hit  = !done_eff && (fill_inc >= w_eff) && !dup;
  assign emit = hit || (in_tlast && !done_eff);

  assign res.found    = hit;
  assign res.position = idx_nxt;

  // line end clears the fill count and done flag for the next byte
  assign fill_nxt = in_tlast ? '0 : fill_inc;
  assign done_nxt = in_tlast ? 1'b0 : (done_eff || hit);

  // ---------------------------------------------------------------- line state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ws_r   <= dwmd_pkg::WS_RESET;
      fill_r <= '0;
      idx_r  <= '0;
      done_r <= 1'b0;
    end else if (cfg_wen) begin
      ws_r   <= cfg_wdata;
      fill_r <= '0;
      idx_r  <= '0;
      done_r <= 1'b0;
    end else if (accept) begin
      fill_r <= fill_nxt;
      idx_r  <= in_tlast ? '0 : idx_nxt;
      done_r <= done_nxt;
    end
  end

  // window only shifts while the line is still searching
  always_ff @(posedge clk) begin
    if (accept && !done_eff) begin
      for (int k = 0; k < dwmd_pkg::MAX_WINDOW; k++) begin
        win_r[k] <= win_nxt[k];
      end
    end
  end

  // ---------------------------------------------------------------- output + skid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (skid_valid_r) begin
      if (pop) begin
        out_valid_r  <= 1'b1;
        skid_valid_r <= 1'b0;
      end
    end else if (accept && emit) begin
      if (!out_valid_r || pop) begin
        out_valid_r <= 1'b1;
      end else begin
        skid_valid_r <= 1'b1;
      end
    end else if (pop) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_valid_r) begin
      if (pop) begin
        out_r <= skid_r;
      end
    end else if (accept && emit) begin
      if (!out_valid_r || pop) begin
        out_r <= res;
      end else begin
        skid_r <= res;
      end
    end
  end

  // ---------------------------------------------------------------- checks
  // the skid slot only fills behind an occupied output register
  a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r |-> out_valid_r)
    else $error("skid register holds a word while output register is empty");

  // fill count stays within the window depth
  a_fill_range: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= dwmd_pkg::FILL_MAX)
    else $error("fill count past window depth");

  // every result reports at least one byte
  a_pos_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_r.position != '0))
    else $error("result with zero position");

  // a line end leaves a cleared line behind it
  a_line_end_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && in_tlast && !cfg_wen) |=> (idx_r == '0) && !done_r && (fill_r == '0))
    else $error("line state not cleared after line end");

endmodule
